// ----- rtl/bgrf_pkg.sv -----
// Shared types and constants for the binary grid rectangle finder.
// No dependencies; compile first.
package bgrf_pkg;

   localparam int FIELD_W    = 9;
   localparam int CSR_DATA_W = 10;
   localparam int CSR_IDX_W  = 1;
   localparam int RESET_DIM  = 512;

   localparam logic [CSR_IDX_W-1:0] CSR_GRID_ROWS = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_GRID_COLS = 1'b1;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef struct packed {
      logic [FIELD_W-1:0] top_row;
      logic [FIELD_W-1:0] left_col;
      logic [FIELD_W-1:0] bottom_row;
      logic [FIELD_W-1:0] right_col;
      logic               run_end;
   } rsp_item_type;

endpackage

// ----- rtl/bgrf_if.sv -----
// Valid/ready channel interfaces for cell beats and rectangle beats.
// Depends on bgrf_pkg.
interface bgrf_req_if;
   logic valid;
   logic ready;
   logic cell_set;

   modport source (output valid, output cell_set, input ready);
   modport sink   (input valid, input cell_set, output ready);
endinterface

interface bgrf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [bgrf_pkg::FIELD_W-1:0] top_row;
   logic [bgrf_pkg::FIELD_W-1:0] left_col;
   logic [bgrf_pkg::FIELD_W-1:0] bottom_row;
   logic [bgrf_pkg::FIELD_W-1:0] right_col;
   logic                         run_end;

   modport source (output valid, output top_row, output left_col, output bottom_row,
                   output right_col, output run_end, input ready);
   modport sink   (input valid, input top_row, input left_col, input bottom_row,
                   input right_col, input run_end, output ready);
endinterface

// ----- rtl/bgrf_line_store.sv -----
// One-row line store: single write port, registered read with same-edge write bypass.
// Depends on bgrf_pkg (house import only).
module bgrf_line_store #(
   parameter int DEPTH  = 512,
   parameter int DATA_W = 19
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);
   import bgrf_pkg::*;

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] q_ff;
   logic [DATA_W-1:0] byp_ff;
   logic              hit_ff;
   logic              hit_in;

   assign hit_in = wr_en && (wr_addr == rd_addr);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         q_ff   <= mem[rd_addr];
         byp_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (rd_en) begin
         hit_ff <= hit_in;
      end
   end

   assign rd_data = hit_ff ? byp_ff : q_ff;

endmodule

// ----- rtl/bgrf_rsp_fifo.sv -----
// Small result queue: up to two beats pushed per cycle, one popped.
// Depends on bgrf_pkg.
module bgrf_rsp_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_a,
   input  logic                   push_b,
   input  bgrf_pkg::rsp_item_type item_a,
   input  bgrf_pkg::rsp_item_type item_b,
   input  logic                   pop,
   output logic                   out_valid,
   output bgrf_pkg::rsp_item_type out_item,
   output logic                   has_room
);
   import bgrf_pkg::*;

   rsp_item_type          slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;
   logic                  do_pop;

   assign do_pop    = pop && (count_ff != '0);
   assign out_valid = (count_ff != '0);
   assign out_item  = slot_ff[rd_ptr_ff];
   assign has_room  = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + FIFO_PTR_W'(push_a) + FIFO_PTR_W'(push_b);
      rd_ptr_in = rd_ptr_ff + FIFO_PTR_W'(do_pop);
      count_in  = count_ff + FIFO_CNT_W'(push_a) + FIFO_CNT_W'(push_b)
                  - FIFO_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push_a) begin
         slot_ff[wr_ptr_ff] <= item_a;
      end
      if (push_b) begin
         slot_ff[FIFO_PTR_W'(wr_ptr_ff + 1'b1)] <= item_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/binary_grid_rectangle_finder.sv -----
// A rectangle beat is queued when its closing cell beat is accepted; rsp shows queue head.
// Throughput: one cell per cycle; each cell is resolved from the line store window.
// req ready drops while the result queue has fewer than two free slots.
// Reset (synchronous, active high): grid 512 x 512 (clamped), scan at row 0 column 0,
// queue empty. Line store contents are not cleared; a register write restarts the scan.
module binary_grid_rectangle_finder #(
   parameter int MAX_ROWS = 512,
   parameter int MAX_COLS = 512
) (
   input  logic                              clock,
   input  logic                              reset,
   bgrf_req_if.sink                          req_bus,
   bgrf_rsp_if.source                        rsp_bus,
   input  logic                              csr_we,
   input  logic [bgrf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [bgrf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import bgrf_pkg::*;

   localparam int CW       = $clog2(MAX_COLS);
   localparam int RW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CDW      = $clog2(MAX_COLS + 1);
   localparam int RDW      = $clog2(MAX_ROWS + 1);
   localparam int LSW      = 1 + RW + CW;
   localparam int ROWS_RST = (MAX_ROWS < RESET_DIM) ? MAX_ROWS : RESET_DIM;
   localparam int COLS_RST = (MAX_COLS < RESET_DIM) ? MAX_COLS : RESET_DIM;

   logic [RDW-1:0] rows_ff, rows_in;
   logic [CDW-1:0] cols_ff, cols_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [CW-1:0]  col_ff, col_in;
   logic           prev_ff, prev_in;
   logic [RW-1:0]  run_top_ff, run_top_in;
   logic [CW-1:0]  run_left_ff, run_left_in;
   logic           ab_ff;
   logic [RW-1:0]  at_ff;
   logic [CW-1:0]  al_ff;
   logic [LSW-1:0] win_in;

   logic           acc, pix;
   logic           last_row, last_col, last_nxt;
   logic [CW-1:0]  nc, nnc;
   logic           up, nxt_bit;
   logic [RW-1:0]  t;
   logic [CW-1:0]  l;
   logic           res_a, res_b, res_c, two;
   logic [LSW-1:0] ls_wdata, ls_q;
   logic           push_a, push_b, q_valid, q_room;
   rsp_item_type   it_a, it_b, it_c, it_bc, item_a, item_b, q_item;

   assign acc = req_bus.valid && req_bus.ready;
   assign pix = req_bus.cell_set;

   always_comb begin
      if (csr_wdata == '0) begin
         rows_in = RDW'(1);
         cols_in = CDW'(1);
      end else begin
         rows_in = (32'(csr_wdata) > MAX_ROWS) ? RDW'(MAX_ROWS) : RDW'(csr_wdata);
         cols_in = (32'(csr_wdata) > MAX_COLS) ? CDW'(MAX_COLS) : CDW'(csr_wdata);
      end
   end

   assign last_row = ((RDW'(row_ff) + RDW'(1)) == rows_ff);
   assign last_col = ((CDW'(col_ff) + CDW'(1)) == cols_ff);
   assign nc       = last_col ? '0 : CW'(col_ff + CW'(1));
   assign last_nxt = ((CDW'(nc) + CDW'(1)) == cols_ff);
   assign nnc      = last_nxt ? '0 : CW'(nc + CW'(1));

   assign nxt_bit = ls_q[LSW-1];
   assign up      = (row_ff != '0) && ab_ff;

   always_comb begin
      if (up) begin
         t = at_ff;
         l = al_ff;
      end else if (prev_ff) begin
         t = run_top_ff;
         l = run_left_ff;
      end else begin
         t = row_ff;
         l = col_ff;
      end
   end

   assign res_a = up && !pix && (last_col || !nxt_bit);
   assign res_b = last_row && prev_ff && !pix;
   assign res_c = last_row && last_col && pix;
   assign two   = res_a && (res_b || res_c);

   always_comb begin
      it_a = '{top_row: FIELD_W'(at_ff), left_col: FIELD_W'(al_ff),
               bottom_row: FIELD_W'(RW'(row_ff - RW'(1))), right_col: FIELD_W'(col_ff),
               run_end: !two};
      it_b = '{top_row: FIELD_W'(run_top_ff), left_col: FIELD_W'(run_left_ff),
               bottom_row: FIELD_W'(row_ff), right_col: FIELD_W'(CW'(col_ff - CW'(1))),
               run_end: 1'b1};
      it_c = '{top_row: FIELD_W'(t), left_col: FIELD_W'(l),
               bottom_row: FIELD_W'(row_ff), right_col: FIELD_W'(col_ff),
               run_end: 1'b1};
      it_bc  = res_b ? it_b : it_c;
      item_a = res_a ? it_a : it_bc;
      item_b = it_bc;
   end

   assign push_a = acc && (res_a || res_b || res_c);
   assign push_b = acc && two;

   assign ls_wdata = {pix, t, l};
   // a one-column grid reuses the entry written by this very beat
   assign win_in   = (nc == col_ff) ? ls_wdata : ls_q;

   always_comb begin
      row_in      = row_ff;
      col_in      = col_ff;
      prev_in     = prev_ff;
      run_top_in  = run_top_ff;
      run_left_in = run_left_ff;
      if (csr_we) begin
         row_in      = '0;
         col_in      = '0;
         prev_in     = 1'b0;
         run_top_in  = '0;
         run_left_in = '0;
      end else if (acc) begin
         run_top_in  = t;
         run_left_in = l;
         col_in      = nc;
         if (last_col) begin
            prev_in = 1'b0;
            row_in  = last_row ? '0 : RW'(row_ff + RW'(1));
         end else begin
            prev_in = pix;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff     <= RDW'(ROWS_RST);
         cols_ff     <= CDW'(COLS_RST);
         row_ff      <= '0;
         col_ff      <= '0;
         prev_ff     <= 1'b0;
         run_top_ff  <= '0;
         run_left_ff <= '0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         prev_ff     <= prev_in;
         run_top_ff  <= run_top_in;
         run_left_ff <= run_left_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_GRID_ROWS: rows_ff <= rows_in;
               CSR_GRID_COLS: cols_ff <= cols_in;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         {ab_ff, at_ff, al_ff} <= win_in;
      end
   end

   bgrf_line_store #(
      .DEPTH  (MAX_COLS),
      .DATA_W (LSW)
   ) u_line_store (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (acc),
      .wr_addr (col_ff),
      .wr_data (ls_wdata),
      .rd_en   (acc),
      .rd_addr (nnc),
      .rd_data (ls_q)
   );

   bgrf_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_a    (push_a),
      .push_b    (push_b),
      .item_a    (item_a),
      .item_b    (item_b),
      .pop       (rsp_bus.ready),
      .out_valid (q_valid),
      .out_item  (q_item),
      .has_room  (q_room)
   );

   assign req_bus.ready      = q_room;
   assign rsp_bus.valid      = q_valid;
   assign rsp_bus.top_row    = q_item.top_row;
   assign rsp_bus.left_col   = q_item.left_col;
   assign rsp_bus.bottom_row = q_item.bottom_row;
   assign rsp_bus.right_col  = q_item.right_col;
   assign rsp_bus.run_end    = q_item.run_end;

endmodule

// ----- rtl/bgrf_checker.sv -----
// Port-level checks on the rectangle finder, bound to the top level.
// Depends on bgrf_pkg and binary_grid_rectangle_finder.
module bgrf_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [bgrf_pkg::FIELD_W-1:0] top_row,
   input logic [bgrf_pkg::FIELD_W-1:0] left_col,
   input logic [bgrf_pkg::FIELD_W-1:0] bottom_row,
   input logic [bgrf_pkg::FIELD_W-1:0] right_col,
   input logic                         run_end
);
   import bgrf_pkg::*;

   // queue is empty straight after reset, so cells are taken at once
   a_ready_after_reset: assert property (@(posedge clock) reset |=> req_ready)
      else $error("req ready low after reset");

   // first beat of a pair is always followed by its partner
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !run_end |=> rsp_valid)
      else $error("second beat of a pair missing");

   a_corner_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (top_row <= bottom_row) && (left_col <= right_col))
      else $error("rectangle corners out of order");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(top_row) && $stable(left_col)
         && $stable(bottom_row) && $stable(right_col) && $stable(run_end))
      else $error("stalled rsp beat changed");

endmodule

bind binary_grid_rectangle_finder bgrf_checker u_bgrf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .top_row    (rsp_bus.top_row),
   .left_col   (rsp_bus.left_col),
   .bottom_row (rsp_bus.bottom_row),
   .right_col  (rsp_bus.right_col),
   .run_end    (rsp_bus.run_end)
);
